// ===== rtl/bsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants for the bank switch mapper: the decoded command
// that travels from the front decoder to the back executor, and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

  // Address decode mask for mapper register writes.
  localparam logic [15:0] ADDR_MASK = 16'hF0CF;

  // Full decoded register addresses.
  localparam logic [15:0] ADDR_PRG_A   = 16'h8000;
  localparam logic [15:0] ADDR_PRG_B   = 16'hA000;
  localparam logic [15:0] ADDR_MIRROR  = 16'h9000;
  localparam logic [15:0] ADDR_MODE_A  = 16'h9002;
  localparam logic [15:0] ADDR_MODE_B  = 16'h9080;

  // Upper address nibbles.
  localparam logic [3:0] TOP_CHR_FIRST = 4'hB;
  localparam logic [3:0] TOP_CHR_LAST  = 4'hE;
  localparam logic [3:0] TOP_IRQ       = 4'hF;

  // Counter value at which a tick overflows.
  localparam logic [7:0] IRQ_COUNT_MAX = 8'hFF;

  // Input operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Result update kinds.
  localparam logic [1:0] UPD_NONE   = 2'd0;
  localparam logic [1:0] UPD_PRG    = 2'd1;
  localparam logic [1:0] UPD_CHR    = 2'd2;
  localparam logic [1:0] UPD_MIRROR = 2'd3;

  // PRG slot numbers.
  localparam logic [2:0] PRG_SLOT_LOW  = 3'd0;
  localparam logic [2:0] PRG_SLOT_MID  = 3'd1;
  localparam logic [2:0] PRG_SLOT_HIGH = 3'd2;

  // Nibble select codes for nibble-wide registers.
  localparam logic [2:0] NIB_FIRST_LO  = 3'd0;
  localparam logic [2:0] NIB_FIRST_HI  = 3'd1;
  localparam logic [2:0] NIB_SECOND_LO = 3'd2;
  localparam logic [2:0] NIB_SECOND_HI = 3'd3;
  localparam logic [2:0] NIB_NONE      = 3'd4;

  // Kinds of work handed to the back end.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_PRG_SWAP,
    CMD_PRG_FIXED,
    CMD_MIRROR,
    CMD_MODE,
    CMD_CHR,
    CMD_RELOAD_LO,
    CMD_RELOAD_HI,
    CMD_ACK,
    CMD_ENABLE,
    CMD_TICK
  } cmd_kind_t;

  // One decoded item.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [2:0] chr_idx;
    logic       chr_high;
    logic [7:0] data;
  } cmd_t;

  // Map the low address byte to a nibble select code.
  function automatic logic [2:0] nibble_select(input logic [7:0] low);
    logic [2:0] sel;
    begin
      case (low)
        8'h00:        sel = NIB_FIRST_LO;
        8'h02, 8'h40: sel = NIB_FIRST_HI;
        8'h01, 8'h04, 8'h80: sel = NIB_SECOND_LO;
        8'h03, 8'h06, 8'hC0: sel = NIB_SECOND_HI;
        default:      sel = NIB_NONE;
      endcase
      return sel;
    end
  endfunction

  // Replace one nibble of a byte with the low nibble of the data.
  function automatic logic [7:0] merge_nibble(input logic [7:0] old_val,
                                              input logic [7:0] data,
                                              input logic       high);
    begin
      if (high) begin
        return {data[3:0], old_val[3:0]};
      end
      return {old_val[7:4], data[3:0]};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bank_switch_mapper_with_scanline_irq.sv =====
// An accepted item is written into the command queue, then executed from the queue
// head into the result register. Throughput: one item per cycle while out_ready is
// high; the front decodes in the accept cycle and the back executes one queued
// command per cycle. The two-entry queue takes up to two items while a result waits.
// Reset: synchronous, active low; CHR bank i holds i, other state and IRQ clear.
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_scanline_irq
// Bank switching mapper with a scanline IRQ counter: decoder front end, command
// queue, and executor back end holding the mapper state.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_switch_mapper_with_scanline_irq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [15:0] in_cpu_address,
  input  wire logic [7:0]  in_write_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_update_kind,
  output logic [2:0]       out_slot_index,
  output logic [7:0]       out_bank_value,
  output logic             out_irq_pulse
);

  bsm_pkg::cmd_t dec_cmd;
  bsm_pkg::cmd_t head_cmd;
  logic          q_full;
  logic          q_not_empty;
  logic          q_pop;
  logic          q_push;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Front end: classify the item.
  bsm_front u_front (
    .operation   (in_operation),
    .cpu_address (in_cpu_address),
    .write_byte  (in_write_byte),
    .cmd         (dec_cmd)
  );

  // Command queue.
  bsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (dec_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  // Back end: execute and register the result.
  bsm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_not_empty),
    .cmd             (head_cmd),
    .cmd_take        (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_update_kind (out_update_kind),
    .out_slot_index  (out_slot_index),
    .out_bank_value  (out_bank_value),
    .out_irq_pulse   (out_irq_pulse)
  );

endmodule

`default_nettype wire

// ===== rtl/bsm_front.sv =====
// ----------------------------------------------------------------------------
// bsm_front
// Classifies each incoming item into a decoded command: register write
// targets are resolved from the masked address, ticks pass as tick commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_front (
  input  wire logic         operation,
  input  wire logic [15:0]  cpu_address,
  input  wire logic [7:0]   write_byte,
  output bsm_pkg::cmd_t     cmd
);

  logic [15:0] addr_m;
  logic [3:0]  top;
  logic [7:0]  low;
  logic [2:0]  sel;
  logic [3:0]  top_off;

  assign addr_m  = cpu_address & bsm_pkg::ADDR_MASK;
  assign top     = addr_m[15:12];
  assign low     = addr_m[7:0];
  assign sel     = bsm_pkg::nibble_select(low);
  assign top_off = top - bsm_pkg::TOP_CHR_FIRST;

  // Address decode into a command for the back end.
  always_comb begin
    cmd.kind     = bsm_pkg::CMD_NONE;
    cmd.chr_idx  = {top_off[1:0], sel[1]};
    cmd.chr_high = sel[0];
    cmd.data     = write_byte;
    if (operation == bsm_pkg::OP_TICK) begin
      cmd.kind = bsm_pkg::CMD_TICK;
    end else if (addr_m == bsm_pkg::ADDR_PRG_A) begin
      cmd.kind = bsm_pkg::CMD_PRG_SWAP;
    end else if (addr_m == bsm_pkg::ADDR_PRG_B) begin
      cmd.kind = bsm_pkg::CMD_PRG_FIXED;
    end else if (addr_m == bsm_pkg::ADDR_MIRROR) begin
      cmd.kind = bsm_pkg::CMD_MIRROR;
    end else if (addr_m == bsm_pkg::ADDR_MODE_A || addr_m == bsm_pkg::ADDR_MODE_B) begin
      cmd.kind = bsm_pkg::CMD_MODE;
    end else if (top >= bsm_pkg::TOP_CHR_FIRST && top <= bsm_pkg::TOP_CHR_LAST) begin
      if (sel != bsm_pkg::NIB_NONE) begin
        cmd.kind = bsm_pkg::CMD_CHR;
      end
    end else if (top == bsm_pkg::TOP_IRQ) begin
      case (low)
        8'h00:        cmd.kind = bsm_pkg::CMD_RELOAD_LO;
        8'h02, 8'h40: cmd.kind = bsm_pkg::CMD_RELOAD_HI;
        8'h03, 8'hC0: cmd.kind = bsm_pkg::CMD_ACK;
        8'h04, 8'h80: cmd.kind = bsm_pkg::CMD_ENABLE;
        default:      cmd.kind = bsm_pkg::CMD_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bsm_queue.sv =====
// ----------------------------------------------------------------------------
// bsm_queue
// Two-entry command queue between the decoder and the executor; either side
// can stall without holding up the other until the queue is full or empty.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  bsm_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output bsm_pkg::cmd_t      head_cmd
);

  bsm_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head_cmd  = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bsm_back.sv =====
// ----------------------------------------------------------------------------
// bsm_back
// Executes decoded commands against the mapper state (CHR banks, PRG mode,
// IRQ counter) and registers one result item per command.
// ----------------------------------------------------------------------------
`default_nettype none

module bsm_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  bsm_pkg::cmd_t      cmd,
  output logic               cmd_take,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_update_kind,
  output logic [2:0]         out_slot_index,
  output logic [7:0]         out_bank_value,
  output logic               out_irq_pulse
);

  logic [7:0] chr_r [8];
  logic [7:0] chr_nxt;
  logic       swap_r, swap_nxt;
  logic [1:0] en_r, en_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] reload_r, reload_nxt;

  logic       valid_r;
  logic [1:0] kind_r, kind_nxt;
  logic [2:0] slot_r, slot_nxt;
  logic [7:0] value_r, value_nxt;
  logic       pulse_r, pulse_nxt;

  // Take a command whenever the result register is free or being emptied.
  assign cmd_take = cmd_valid && (!valid_r || out_ready);

  assign out_valid       = valid_r;
  assign out_update_kind = kind_r;
  assign out_slot_index  = slot_r;
  assign out_bank_value  = value_r;
  assign out_irq_pulse   = pulse_r;

  // Command execution: next state and result.
  always_comb begin
    chr_nxt    = bsm_pkg::merge_nibble(chr_r[cmd.chr_idx], cmd.data, cmd.chr_high);
    swap_nxt   = swap_r;
    en_nxt     = en_r;
    cnt_nxt    = cnt_r;
    reload_nxt = reload_r;
    kind_nxt   = bsm_pkg::UPD_NONE;
    slot_nxt   = 3'd0;
    value_nxt  = 8'd0;
    pulse_nxt  = 1'b0;
    case (cmd.kind)
      bsm_pkg::CMD_PRG_SWAP: begin
        kind_nxt  = bsm_pkg::UPD_PRG;
        slot_nxt  = swap_r ? bsm_pkg::PRG_SLOT_HIGH : bsm_pkg::PRG_SLOT_LOW;
        value_nxt = cmd.data;
      end
      bsm_pkg::CMD_PRG_FIXED: begin
        kind_nxt  = bsm_pkg::UPD_PRG;
        slot_nxt  = bsm_pkg::PRG_SLOT_MID;
        value_nxt = cmd.data;
      end
      bsm_pkg::CMD_MIRROR: begin
        kind_nxt  = bsm_pkg::UPD_MIRROR;
        value_nxt = {6'd0, cmd.data[1:0]};
      end
      bsm_pkg::CMD_MODE: begin
        swap_nxt = cmd.data[1];
      end
      bsm_pkg::CMD_CHR: begin
        kind_nxt  = bsm_pkg::UPD_CHR;
        slot_nxt  = cmd.chr_idx;
        value_nxt = chr_nxt;
      end
      bsm_pkg::CMD_RELOAD_LO: begin
        reload_nxt = bsm_pkg::merge_nibble(reload_r, cmd.data, 1'b0);
      end
      bsm_pkg::CMD_RELOAD_HI: begin
        reload_nxt = bsm_pkg::merge_nibble(reload_r, cmd.data, 1'b1);
      end
      bsm_pkg::CMD_ACK: begin
        en_nxt = {en_r[0], en_r[0]};
      end
      bsm_pkg::CMD_ENABLE: begin
        en_nxt = cmd.data[1:0];
        if (cmd.data[1]) begin
          cnt_nxt = reload_r;
        end
      end
      bsm_pkg::CMD_TICK: begin
        if (en_r[1]) begin
          if (cnt_r == bsm_pkg::IRQ_COUNT_MAX) begin
            cnt_nxt   = reload_r;
            en_nxt    = {en_r[0], en_r[0]};
            pulse_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 8'd1;
          end
        end
      end
      default: begin
        kind_nxt = bsm_pkg::UPD_NONE;
      end
    endcase
  end

  // Control state and IRQ registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r   <= 1'b0;
      en_r     <= 2'd0;
      cnt_r    <= 8'd0;
      reload_r <= 8'd0;
      valid_r  <= 1'b0;
    end else begin
      if (cmd_take) begin
        swap_r   <= swap_nxt;
        en_r     <= en_nxt;
        cnt_r    <= cnt_nxt;
        reload_r <= reload_nxt;
        valid_r  <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // CHR bank registers; entry i resets to i.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        chr_r[i] <= {5'd0, 3'(i)};
      end
    end else if (cmd_take && cmd.kind == bsm_pkg::CMD_CHR) begin
      chr_r[cmd.chr_idx] <= chr_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      kind_r  <= kind_nxt;
      slot_r  <= slot_nxt;
      value_r <= value_nxt;
      pulse_r <= pulse_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== tb/bank_switch_mapper_with_scanline_irq_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_scanline_irq_test
// Self-checking bench for the bank switch mapper. A small scoreboard tracks the
// mapper's registers and IRQ counter, predicts the update for every accepted
// item and checks each result against it. Directed register writes and ticks
// come first, then random register sequences, IRQ countdowns and bus noise,
// with random stalls on both sides, a long output hold-off and a full drain.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_switch_mapper_with_scanline_irq_test;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [15:0] UNMASKED_BITS = ~bsm_pkg::ADDR_MASK;

  // One mapper update as it appears on the result channel.
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] slot;
    logic [7:0] value;
    logic       pulse;
  } bank_update_t;

  // Tracks the mapper state and the updates still to come out of the block.
  class bank_update_tracker;
    logic [7:0]   chr_banks [8];
    logic         swap_mode;
    logic [1:0]   irq_enable;
    logic [7:0]   irq_counter;
    logic [7:0]   irq_latch;
    bank_update_t expected_updates [$];
    int errors;
    int prg_seen, chr_seen, mirror_seen, pulses_seen, results_seen;

    function new();
      for (int i = 0; i < 8; i++) begin
        chr_banks[i] = 8'(i);
      end
      swap_mode   = 1'b0;
      irq_enable  = 2'b00;
      irq_counter = 8'h00;
      irq_latch   = 8'h00;
      errors      = 0;
      prg_seen    = 0;
      chr_seen    = 0;
      mirror_seen = 0;
      pulses_seen = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_updates.size();
    endfunction

    // Apply one accepted item to the tracked state and queue its update.
    function void note_item(logic op, logic [15:0] addr, logic [7:0] data);
      bank_update_t upd;
      logic [15:0]  dec;
      logic [3:0]   chr_group;
      logic [2:0]   idx;
      logic         pair, high, hit;
      upd = '0;
      dec = addr & bsm_pkg::ADDR_MASK;
      if (op == bsm_pkg::OP_TICK) begin
        // The counter runs only while the counting bit is set.
        if (irq_enable[1]) begin
          if (irq_counter == bsm_pkg::IRQ_COUNT_MAX) begin
            irq_counter = irq_latch;
            irq_enable  = {2{irq_enable[0]}};
            upd.pulse   = 1'b1;
          end else begin
            irq_counter = irq_counter + 8'd1;
          end
        end
      end else if (dec == bsm_pkg::ADDR_PRG_A) begin
        upd.kind  = bsm_pkg::UPD_PRG;
        upd.slot  = swap_mode ? bsm_pkg::PRG_SLOT_HIGH : bsm_pkg::PRG_SLOT_LOW;
        upd.value = data;
      end else if (dec == bsm_pkg::ADDR_PRG_B) begin
        upd.kind  = bsm_pkg::UPD_PRG;
        upd.slot  = bsm_pkg::PRG_SLOT_MID;
        upd.value = data;
      end else if (dec == bsm_pkg::ADDR_MIRROR) begin
        upd.kind  = bsm_pkg::UPD_MIRROR;
        upd.value = {6'b0, data[1:0]};
      end else if (dec == bsm_pkg::ADDR_MODE_A || dec == bsm_pkg::ADDR_MODE_B) begin
        swap_mode = data[1];
      end else if (dec[15:12] >= bsm_pkg::TOP_CHR_FIRST &&
                   dec[15:12] <= bsm_pkg::TOP_CHR_LAST) begin
        // Each upper nibble holds two CHR registers, written a nibble at a time.
        hit  = 1'b1;
        pair = 1'b0;
        high = 1'b0;
        case (dec[7:0])
          8'h00:               begin pair = 1'b0; high = 1'b0; end
          8'h02, 8'h40:        begin pair = 1'b0; high = 1'b1; end
          8'h01, 8'h04, 8'h80: begin pair = 1'b1; high = 1'b0; end
          8'h03, 8'h06, 8'hC0: begin pair = 1'b1; high = 1'b1; end
          default:             hit = 1'b0;
        endcase
        if (hit) begin
          chr_group = dec[15:12] - bsm_pkg::TOP_CHR_FIRST;
          idx = {chr_group[1:0], pair};
          if (high) begin
            chr_banks[idx][7:4] = data[3:0];
          end else begin
            chr_banks[idx][3:0] = data[3:0];
          end
          upd.kind  = bsm_pkg::UPD_CHR;
          upd.slot  = idx;
          upd.value = chr_banks[idx];
        end
      end else if (dec[15:12] == bsm_pkg::TOP_IRQ) begin
        // IRQ latch nibbles, acknowledge and enable; none of them reports.
        case (dec[7:0])
          8'h00:        irq_latch[3:0] = data[3:0];
          8'h02, 8'h40: irq_latch[7:4] = data[3:0];
          8'h03, 8'hC0: irq_enable = {2{irq_enable[0]}};
          8'h04, 8'h80: begin
            irq_enable = data[1:0];
            if (data[1]) begin
              irq_counter = irq_latch;
            end
          end
          default: ;
        endcase
      end
      expected_updates.push_back(upd);
    endfunction

    function bit field_ok(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    // Compare one accepted result with the oldest expected update.
    function void check_update(logic [1:0] kind, logic [2:0] slot, logic [7:0] value,
                               logic pulse);
      bank_update_t want;
      bit ok;
      if (expected_updates.size() == 0) begin
        $display("%0t: unexpected result, kind %0d slot %0d value %0d pulse %0d",
                 $time, kind, slot, value, pulse);
        errors++;
        return;
      end
      want = expected_updates.pop_front();
      ok = field_ok("update_kind", 8'(want.kind), 8'(kind));
      ok = field_ok("slot_index", 8'(want.slot), 8'(slot)) && ok;
      ok = field_ok("bank_value", want.value, value) && ok;
      ok = field_ok("irq_pulse", 8'(want.pulse), 8'(pulse)) && ok;
      if (!ok) begin
        errors++;
      end
      results_seen++;
      case (want.kind)
        bsm_pkg::UPD_PRG:    prg_seen++;
        bsm_pkg::UPD_CHR:    chr_seen++;
        bsm_pkg::UPD_MIRROR: mirror_seen++;
        default: ;
      endcase
      if (want.pulse) begin
        pulses_seen++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = bsm_pkg::OP_WRITE;
  logic [15:0] in_cpu_address = 16'h0000;
  logic [7:0]  in_write_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_update_kind;
  logic [2:0]  out_slot_index;
  logic [7:0]  out_bank_value;
  logic        out_irq_pulse;

  bank_update_tracker board;
  int items_sent = 0;
  int ticks_sent = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;

  // Low address bytes that hit the CHR and IRQ register groups.
  logic [7:0] chr_lows [9] = '{8'h00, 8'h02, 8'h40, 8'h01, 8'h04, 8'h80, 8'h03, 8'h06, 8'hC0};
  logic [7:0] irq_lows [7] = '{8'h00, 8'h02, 8'h40, 8'h03, 8'hC0, 8'h04, 8'h80};

  bank_switch_mapper_with_scanline_irq dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_cpu_address  (in_cpu_address),
    .in_write_byte   (in_write_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_update_kind (out_update_kind),
    .out_slot_index  (out_slot_index),
    .out_bank_value  (out_bank_value),
    .out_irq_pulse   (out_irq_pulse)
  );

  always #5 clk = ~clk;

  // Result side: check accepted results and drive out_ready, with one long hold-off.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_update(out_update_kind, out_slot_index, out_bank_value, out_irq_pulse);
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cycles <= 80;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 23);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, board.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item, with an occasional idle cycle in front of it.
  task automatic send_item(input logic op, input logic [15:0] addr, input logic [7:0] data);
    if (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_cpu_address <= addr;
    in_write_byte  <= data;
    do @(posedge clk); while (!in_ready);
    board.note_item(op, addr, data);
    items_sent++;
    if (op == bsm_pkg::OP_TICK) begin
      ticks_sent++;
    end
  endtask

  // Stop offering items until every expected result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Set random address bits that the decoder ignores, half of the time.
  function automatic logic [15:0] with_noise(input logic [15:0] addr);
    if ($urandom_range(1) == 1) begin
      return addr | (16'($urandom) & UNMASKED_BITS);
    end
    return addr;
  endfunction

  // Pick the address of some mapper register.
  function automatic logic [15:0] pick_reg_addr();
    logic [15:0] base;
    case ($urandom_range(7))
      0:       base = bsm_pkg::ADDR_PRG_A;
      1:       base = bsm_pkg::ADDR_PRG_B;
      2:       base = bsm_pkg::ADDR_MIRROR;
      3:       base = $urandom_range(1) ? bsm_pkg::ADDR_MODE_A : bsm_pkg::ADDR_MODE_B;
      4, 5:    base = {4'($urandom_range(11, 14)), 4'h0, chr_lows[$urandom_range(8)]};
      default: base = {bsm_pkg::TOP_IRQ, 4'h0, irq_lows[$urandom_range(6)]};
    endcase
    return with_noise(base);
  endfunction

  // Load a high latch, enable counting, tick toward overflow, sometimes acknowledge.
  task automatic irq_countdown();
    logic [7:0] data;
    int ticks;
    send_item(bsm_pkg::OP_WRITE, with_noise({bsm_pkg::TOP_IRQ, 12'h000}), 8'($urandom));
    data = 8'($urandom);
    if ($urandom_range(99) < 70) begin
      data[3:0] = 4'hF;
    end
    send_item(bsm_pkg::OP_WRITE, with_noise($urandom_range(1) ? 16'hF002 : 16'hF040), data);
    data = 8'($urandom);
    if ($urandom_range(99) < 85) begin
      data[1] = 1'b1;
    end
    send_item(bsm_pkg::OP_WRITE, with_noise($urandom_range(1) ? 16'hF004 : 16'hF080), data);
    ticks = $urandom_range(1, 24);
    repeat (ticks) send_item(bsm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
    if ($urandom_range(1) == 1) begin
      send_item(bsm_pkg::OP_WRITE, with_noise($urandom_range(1) ? 16'hF003 : 16'hF0C0),
                8'($urandom));
      ticks = $urandom_range(0, 6);
      repeat (ticks) send_item(bsm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
    end
  endtask

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
  } bus_item_t;

  // Directed items: every register kind, the address extremes and an overflow.
  bus_item_t directed [] = '{
    '{bsm_pkg::OP_WRITE, 16'h8000, 8'hFF},   // PRG slot 0 while the swap mode is clear
    '{bsm_pkg::OP_WRITE, 16'hA000, 8'h00},
    '{bsm_pkg::OP_WRITE, 16'h9000, 8'hFF},   // mirroring keeps only two bits
    '{bsm_pkg::OP_WRITE, 16'h9002, 8'h02},   // swap mode set
    '{bsm_pkg::OP_WRITE, 16'h8F30, 8'h5A},   // ignored address bits, PRG slot 2
    '{bsm_pkg::OP_WRITE, 16'h9080, 8'hFD},   // swap mode cleared by bit 1
    '{bsm_pkg::OP_WRITE, 16'h8000, 8'h01},
    '{bsm_pkg::OP_WRITE, 16'hB000, 8'hAF},
    '{bsm_pkg::OP_WRITE, 16'hB040, 8'h3C},
    '{bsm_pkg::OP_WRITE, 16'hB004, 8'hFF},
    '{bsm_pkg::OP_WRITE, 16'hB0C0, 8'h00},
    '{bsm_pkg::OP_WRITE, 16'hC002, 8'h12},
    '{bsm_pkg::OP_WRITE, 16'hD006, 8'h56},
    '{bsm_pkg::OP_WRITE, 16'hE001, 8'hBC},
    '{bsm_pkg::OP_WRITE, 16'h0000, 8'hFF},   // unmapped addresses
    '{bsm_pkg::OP_WRITE, 16'hFFFF, 8'h00},
    '{bsm_pkg::OP_WRITE, 16'hB008, 8'h11},
    '{bsm_pkg::OP_WRITE, 16'hF000, 8'hFE},   // latch 0xFE, then enable with re-arm
    '{bsm_pkg::OP_WRITE, 16'hF040, 8'hFF},
    '{bsm_pkg::OP_WRITE, 16'hF080, 8'h03},
    '{bsm_pkg::OP_TICK,  16'hFFFF, 8'hFF},
    '{bsm_pkg::OP_TICK,  16'h0000, 8'h00},   // overflow
    '{bsm_pkg::OP_WRITE, 16'hF003, 8'h00},   // acknowledge
    '{bsm_pkg::OP_WRITE, 16'hF004, 8'h00},   // counting off
    '{bsm_pkg::OP_TICK,  16'h1234, 8'h56}    // tick while disabled
  };

  initial begin
    bit did_hold, did_drain;
    int r, n;
    board = new();
    did_hold = 1'b0;
    did_drain = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].addr, directed[i].data);
    end

    // Random part: register traffic, IRQ countdowns and raw bus noise.
    while (items_sent < RANDOM_ITEMS + directed.size()) begin
      quiet = (items_sent >= 500 && items_sent < 800);
      r = $urandom_range(99);
      if (r < 55) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(99) < 30) begin
            send_item(bsm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
          end else begin
            send_item(bsm_pkg::OP_WRITE, pick_reg_addr(), 8'($urandom));
          end
        end
      end else if (r < 80) begin
        irq_countdown();
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(1'($urandom), 16'($urandom), 8'($urandom));
      end
      // Hold the result side off while items keep coming, once.
      if (!did_hold && items_sent >= 300) begin
        hold_req = 1'b1;
        did_hold = 1'b1;
      end
      // Let the block run empty once in the middle of the run.
      if (!did_drain && items_sent >= 900) begin
        wait_drained();
        did_drain = 1'b1;
      end
    end
    quiet = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d items (%0d ticks); checked %0d results with %0d errors.",
             items_sent, ticks_sent, board.results_seen, board.errors);
    $display("Updates seen: %0d PRG, %0d CHR, %0d mirroring, %0d IRQ pulses.",
             board.prg_seen, board.chr_seen, board.mirror_seen, board.pulses_seen);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== bank_switch_mapper_with_scanline_irq.f =====
rtl/bsm_pkg.sv
rtl/bsm_front.sv
rtl/bsm_queue.sv
rtl/bsm_back.sv
rtl/bank_switch_mapper_with_scanline_irq.sv
tb/bank_switch_mapper_with_scanline_irq_test.sv
